// ----- src/keyed_record_deque_macros.svh -----
// assertion macros for the keyed record deque
// used by the top level, needs clk and rst_n in scope
`ifndef KEYED_RECORD_DEQUE_MACROS_SVH
`define KEYED_RECORD_DEQUE_MACROS_SVH

// same-cycle implication
`define KRD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_record_deque check failed");

// next-cycle implication
`define KRD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_record_deque check failed");

`endif

// ----- src/kdq_pkg.sv -----
// shared constants, types and helpers for the keyed record deque
// no dependencies
package kdq_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_LIST       = 3'd4,
        CMD_FIND       = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_WALK
    } state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] key;
        logic [15:0]        value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] rec_key;
        logic [15:0]        rec_value;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        value;
    } rec_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        rec_t             data;
    } ram_wr_t;

    // physical slot of the record at a given offset from the front
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

// ----- src/keyed_record_deque.sv -----
// keyed record deque top level: sequencer plus record storage
// depends on kdq_pkg, kdq_ram, kdq_ctrl and keyed_record_deque_macros.svh
//
// channel   ports             handshake
// command   req (req_t)       accepted when start is high and busy is low
// result    rsp (rsp_t)       one beat per cycle with valid high, always taken
//
// push: the result is registered from the dispatch state; pop: from the pop state, after the storage read
// list: results stream one per cycle from the walk state, one per record
// find: one stored record compared per cycle on the single read port
// busy drops in the cycle the final beat shows, so the next command may follow at once
// reset empties the deque (head and count cleared); storage is not cleared
`include "keyed_record_deque_macros.svh"

module keyed_record_deque
    import kdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic valid,
    output rsp_t rsp
);

    ram_wr_t          wr;
    logic [PTR_W-1:0] rd_addr;
    rec_t             rd_data;

    kdq_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kdq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .valid   (valid),
        .rsp     (rsp),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    `KRD_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `KRD_ASSERT_NXT(a_list_stream, valid && !rsp.last, valid)
    `KRD_ASSERT_IMP(a_beat_after_work, valid, $past(busy))

endmodule

// ----- src/kdq_ram.sv -----
// record storage, one write port and one registered read port
// depends on kdq_pkg
module kdq_ram
    import kdq_pkg::*;
(
    input  logic             clk,
    input  ram_wr_t          wr,
    input  logic [PTR_W-1:0] rd_addr,
    output rec_t             rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/kdq_ctrl.sv -----
// command sequencer: pointers, store walk, key compare and result register
// depends on kdq_pkg
module kdq_ctrl
    import kdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             valid,
    output rsp_t             rsp,
    output ram_wr_t          wr,
    output logic [PTR_W-1:0] rd_addr,
    input  rec_t             rd_data
);

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic             valid_reg, valid_next;
    rsp_t             rsp_reg, rsp_next;
    logic [CNT_W-1:0] rd_off;
    logic [CNT_W-1:0] idx_inc;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] head_inc;
    logic             key_hit;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign key_hit  = (rd_data.key == req_reg.key);
    assign rd_addr  = slot_of(head_reg, rd_off);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        limit_reg <= limit_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        limit_next = limit_reg;
        valid_next = 1'b0;
        rsp_next   = '{status: ST_OK, rec_key: '0, rec_value: '0, last: 1'b1};
        wr         = '0;
        rd_off     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next = S_IDLE;
                unique case (req_reg.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_REAR:
                    begin
                        valid_next = 1'b1;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr.en   = 1'b1;
                            wr.data = '{key: req_reg.key, value: req_reg.value};
                            if (req_reg.cmd == CMD_PUSH_FRONT)
                            begin
                                wr.addr   = head_dec;
                                head_next = head_dec;
                            end
                            else
                            begin
                                wr.addr = slot_of(head_reg, count_reg);
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end

                    CMD_POP_FRONT, CMD_POP_REAR:
                    begin
                        if (count_reg == '0)
                        begin
                            valid_next      = 1'b1;
                            rsp_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            if (req_reg.cmd == CMD_POP_REAR)
                            begin
                                rd_off = count_reg - CNT_W'(1);
                            end
                            state_next = S_POP;
                        end
                    end

                    CMD_LIST, CMD_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            valid_next      = 1'b1;
                            rsp_next.status = (req_reg.cmd == CMD_LIST) ? ST_EMPTY
                                                                        : ST_NOT_FOUND;
                        end
                        else
                        begin
                            idx_next = '0;
                            if (req_reg.cmd == CMD_LIST && 32'(count_reg) > MAX_RESULTS)
                            begin
                                limit_next = CNT_W'(MAX_RESULTS);
                            end
                            else
                            begin
                                limit_next = count_reg;
                            end
                            state_next = S_WALK;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_POP:
            begin
                valid_next         = 1'b1;
                rsp_next.rec_key   = rd_data.key;
                rsp_next.rec_value = rd_data.value;
                if (req_reg.cmd == CMD_POP_FRONT)
                begin
                    head_next = head_inc;
                end
                count_next = count_reg - CNT_W'(1);
                state_next = S_IDLE;
            end

            S_WALK:
            begin
                rd_off = idx_inc;
                if (req_reg.cmd == CMD_LIST)
                begin
                    valid_next         = 1'b1;
                    rsp_next.rec_key   = rd_data.key;
                    rsp_next.rec_value = rd_data.value;
                    rsp_next.last      = (idx_inc == limit_reg);
                    if (idx_inc == limit_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (key_hit)
                begin
                    valid_next         = 1'b1;
                    rsp_next.rec_key   = rd_data.key;
                    rsp_next.rec_value = rd_data.value;
                    state_next         = S_IDLE;
                end
                else if (idx_inc == limit_reg)
                begin
                    valid_next      = 1'b1;
                    rsp_next.status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                idx_next = idx_inc;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg != S_IDLE);
    assign valid = valid_reg;
    assign rsp   = rsp_reg;

endmodule

// ----- verif/tb_keyed_record_deque.sv -----
// self-checking testbench for keyed_record_deque: directed and random command beats
// predicts every result beat in a small scoreboard class and compares on each strobe
// depends on kdq_pkg and the keyed_record_deque rtl
module tb_keyed_record_deque;
    import kdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class deque_tracker;
        logic signed [31:0] keys [DEPTH];
        logic [15:0]        vals [DEPTH];
        int                 head;
        int                 count;
        rsp_t               pending_beats [$];
        int                 errs;

        function new();
            head  = 0;
            count = 0;
            errs  = 0;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function void expect_beat(status_t st, logic signed [31:0] k, logic [15:0] v,
                                  logic lst);
            rsp_t b;
            b.status    = st;
            b.rec_key   = k;
            b.rec_value = v;
            b.last      = lst;
            pending_beats.push_back(b);
        endfunction

        function void note_command(req_t r);
            int s;
            int n;
            bit hit;
            case (r.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR:
                begin
                    if (count >= DEPTH)
                    begin
                        expect_beat(ST_FULL, '0, '0, 1'b1);
                    end
                    else
                    begin
                        if (r.cmd == CMD_PUSH_FRONT)
                        begin
                            head = (head + DEPTH - 1) % DEPTH;
                            s = head;
                        end
                        else
                        begin
                            s = (head + count) % DEPTH;
                        end
                        keys[s] = r.key;
                        vals[s] = r.value;
                        count++;
                        expect_beat(ST_OK, '0, '0, 1'b1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR:
                begin
                    if (count == 0)
                    begin
                        expect_beat(ST_EMPTY, '0, '0, 1'b1);
                    end
                    else
                    begin
                        s = (r.cmd == CMD_POP_FRONT) ? head : (head + count - 1) % DEPTH;
                        expect_beat(ST_OK, keys[s], vals[s], 1'b1);
                        if (r.cmd == CMD_POP_FRONT)
                        begin
                            head = (head + 1) % DEPTH;
                        end
                        count--;
                    end
                end
                CMD_LIST:
                begin
                    if (count == 0)
                    begin
                        expect_beat(ST_EMPTY, '0, '0, 1'b1);
                    end
                    else
                    begin
                        n = (count > MAX_RESULTS) ? MAX_RESULTS : count;
                        for (int i = 0; i < n; i++)
                        begin
                            s = (head + i) % DEPTH;
                            expect_beat(ST_OK, keys[s], vals[s], i == n - 1);
                        end
                    end
                end
                CMD_FIND:
                begin
                    hit = 1'b0;
                    for (int i = 0; i < count && !hit; i++)
                    begin
                        s = (head + i) % DEPTH;
                        if (keys[s] == r.key)
                        begin
                            expect_beat(ST_OK, keys[s], vals[s], 1'b1);
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                    begin
                        expect_beat(ST_NOT_FOUND, '0, '0, 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            errs++;
            $display("%0t mismatch on %s: expected %0h got %0h", $realtime, what, want,
                     got);
        endtask

        task check_beat(rsp_t got);
            rsp_t want;
            if (pending_beats.size() == 0)
            begin
                report_mismatch("unexpected result beat", '0, 64'(got));
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got.status !== want.status)
                begin
                    report_mismatch("status", 64'(want.status), 64'(got.status));
                end
                if (got.rec_key !== want.rec_key)
                begin
                    report_mismatch("rec_key", 64'(want.rec_key), 64'(got.rec_key));
                end
                if (got.rec_value !== want.rec_value)
                begin
                    report_mismatch("rec_value", 64'(want.rec_value), 64'(got.rec_value));
                end
                if (got.last !== want.last)
                begin
                    report_mismatch("last", 64'(want.last), 64'(got.last));
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic valid;
    rsp_t rsp;

    deque_tracker sb = new();

    keyed_record_deque DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .valid (valid),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_command(req);
            end
            if (valid)
            begin
                sb.check_beat(rsp);
            end
        end
    end

    function automatic req_t make_req(cmd_t c, logic signed [31:0] k, logic [15:0] v);
        req_t r;
        r.cmd   = c;
        r.key   = k;
        r.value = v;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_key();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
        begin
            return 32'($urandom_range(0, 7)) - 32'sd4;
        end
        else if (p < 55)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 99) < 10)
        begin
            return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end
        return 16'($urandom);
    endfunction

    // mode 0 leans to pushes, 1 to pops, 2 is even
    function automatic req_t random_command(int mode);
        int p;
        cmd_t c;
        p = $urandom_range(0, 99);
        if (p < 2)
        begin
            c = cmd_t'(3'($urandom_range(6, 7)));
        end
        else if (mode == 0)
        begin
            c = (p < 72) ? cmd_t'(3'($urandom_range(0, 1)))
              : (p < 86) ? cmd_t'(3'($urandom_range(2, 3)))
              : (p < 92) ? CMD_LIST : CMD_FIND;
        end
        else if (mode == 1)
        begin
            c = (p < 67) ? cmd_t'(3'($urandom_range(2, 3)))
              : (p < 82) ? cmd_t'(3'($urandom_range(0, 1)))
              : (p < 88) ? CMD_LIST : CMD_FIND;
        end
        else
        begin
            c = cmd_t'(3'($urandom_range(0, 5)));
        end
        return make_req(c, pick_key(), pick_value());
    endfunction

    task automatic send_command(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 99) < 6)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        req_t directed [$];
        req_t r;
        int   sent;
        int   mode;
        int   len;
        bit   paused;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed.push_back(make_req(CMD_POP_FRONT, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_POP_REAR, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_LIST, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_FIND, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_PUSH_FRONT, 32'sh7fffffff, 16'hffff));
        directed.push_back(make_req(CMD_PUSH_REAR, 32'sh80000000, 16'h0000));
        directed.push_back(make_req(CMD_PUSH_FRONT, 32'sh80000000, 16'h1234));
        directed.push_back(make_req(CMD_LIST, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_FIND, 32'sh80000000, 16'h0));
        directed.push_back(make_req(CMD_FIND, 32'sh7fffffff, 16'h0));
        directed.push_back(make_req(CMD_FIND, 32'sd5, 16'h0));
        directed.push_back(make_req(cmd_t'(3'd6), 32'sd1, 16'h1));
        directed.push_back(make_req(cmd_t'(3'd7), -32'sd1, 16'hffff));
        directed.push_back(make_req(CMD_POP_REAR, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_POP_FRONT, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_POP_FRONT, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_POP_REAR, 32'sd0, 16'h0));
        directed.push_back(make_req(CMD_LIST, 32'sd0, 16'h0));
        foreach (directed[i])
        begin
            send_command(directed[i]);
            maybe_idle(1'b1);
        end
        drain();

        sent   = 0;
        paused = 1'b0;
        while (sent < 455)
        begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 50);
            for (int i = 0; i < len && sent < 455; i++)
            begin
                r = random_command(mode);
                send_command(r);
                if (r.cmd <= CMD_FIND)
                begin
                    sent++;
                end
                maybe_idle(sent < 150 || sent > 260);
                if (!paused && sent >= 300)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.errs == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
